>>> hdl/hee_pkg.sv
`timescale 1ns / 1ps

package hee_pkg;

	// Default grid length, including both boundary points
	localparam int MAX_POINTS_DEF = 256;

	// Field widths
	localparam int VAL_W   = 24;
	localparam int IDX_W   = 8;
	localparam int OP_W    = 2;
	localparam int RATIO_W = 16;
	localparam int NPTS_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Stencil arithmetic widths
	localparam int DIFF_W = VAL_W + 2;            // l + r - 2c
	localparam int PROD_W = DIFF_W + RATIO_W + 1; // signed product
	localparam int FRAC_W = 16;                   // ratio fraction bits

	// Opcodes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd1;

	// Register reset values
	localparam logic [RATIO_W-1:0] RATIO_RST  = 16'd13107;
	localparam logic [NPTS_W-1:0]  POINTS_RST = 9'd256;

	// Saturation limits
	localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

	typedef logic signed [VAL_W-1:0] temp_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [IDX_W-1:0] point_index;
		temp_t            point_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] read_index;
		temp_t            read_value;
	} result_t;

endpackage

>>> hdl/heat_equation_explicit_stencil.sv
`timescale 1ns / 1ps

// FTCS solver for the 1D heat equation on a rod held at zero at both ends.
// The row of Q3.20 temperatures lives in a single-port-write, single-port-read
// memory of MAX_POINTS entries, which comes up unwritten: load every point in
// use before the first advance or read. A read waits for the result register to
// be taken; a load or advance may be accepted while a read result is pending.
// An advance streams every point of the clamped row once through the memory read
// port into one shared multiply-and-saturate unit: the accepting cycle, one read
// per point, the pipeline drain, two boundary writes; the memory read port sets
// its pace. The block is not ready for a new item during an advance. The user
// must write configuration registers only while idle; the block itself does
// not enforce it.
module heat_equation_explicit_stencil
	import hee_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN,
		ST_END_LO,
		ST_END_HI
	} state_t;

	state_t state_q;

	logic [RATIO_W-1:0] ratio_q;
	logic [NPTS_W-1:0]  points_q;

	logic [AW-1:0]    rd_cnt_q;
	logic [AW-1:0]    last_q;
	logic             rv_q;
	logic [AW-1:0]    ridx_q;
	logic [IDX_W-1:0] rd_index_q;
	logic             rd_oob_q;

	logic          accept;
	logic          idx_in_row;
	logic [AW-1:0] item_addr;
	int            n_eff;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	temp_t         mem_wdata, mem_rdata;

	logic          upd_valid, upd_busy;
	logic [AW-1:0] upd_idx;
	temp_t         upd_value;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;
	assign idx_in_row = int'(item.point_index) < MAX_POINTS;
	assign item_addr  = AW'(item.point_index);

	// Point count clamped to the row
	always_comb begin
		n_eff = int'(points_q);
		if (n_eff < 3) begin
			n_eff = 3;
		end
		if (n_eff > MAX_POINTS) begin
			n_eff = MAX_POINTS;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RST;
			points_q <= POINTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RATIO) begin
				ratio_q <= cfg_data[RATIO_W-1:0];
			end else if (cfg_index == CFG_POINTS) begin
				points_q <= cfg_data[NPTS_W-1:0];
			end
		end
	end

	// Memory read port: item reads and the sweep
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rd_cnt_q;
		if (state_q == ST_SWEEP) begin
			mem_re = 1'b1;
		end else if (accept && item.opcode == OP_READ && idx_in_row) begin
			mem_re    = 1'b1;
			mem_raddr = item_addr;
		end
	end

	// Memory write port: loads, stencil results, boundary zeros
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = item_addr;
		mem_wdata = item.point_value;
		priority if (accept && item.opcode == OP_LOAD && idx_in_row) begin
			mem_we = 1'b1;
		end else if (upd_valid) begin
			mem_we    = 1'b1;
			mem_waddr = upd_idx;
			mem_wdata = upd_value;
		end else if (state_q == ST_END_LO) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = '0;
		end else if (state_q == ST_END_HI) begin
			mem_we    = 1'b1;
			mem_waddr = last_q;
			mem_wdata = '0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			rv_q         <= 1'b0;
			rd_cnt_q     <= '0;
			last_q       <= '0;
			ridx_q       <= '0;
			rd_index_q   <= '0;
			rd_oob_q     <= 1'b0;
			result       <= '0;
		end else begin
			// Result valid: set by a new read result, cleared by its transfer
			if (state_q == ST_READ && (!result_valid || result_ready)) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			rv_q   <= (state_q == ST_SWEEP);
			ridx_q <= rd_cnt_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.opcode == OP_READ) begin
							rd_index_q <= item.point_index;
							rd_oob_q   <= !idx_in_row;
							state_q    <= ST_READ;
						end else if (item.opcode == OP_ADVANCE) begin
							rd_cnt_q <= '0;
							last_q   <= AW'(n_eff - 1);
							state_q  <= ST_SWEEP;
						end
					end
				end
				ST_READ: begin
					if (!result_valid || result_ready) begin
						result.read_index <= rd_index_q;
						result.read_value <= rd_oob_q ? temp_t'(0) : mem_rdata;
						state_q           <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (rd_cnt_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_cnt_q <= rd_cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!rv_q && !upd_busy) begin
						state_q <= ST_END_LO;
					end
				end
				ST_END_LO: begin
					state_q <= ST_END_HI;
				end
				ST_END_HI: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	hee_row_mem #(
		.DEPTH (MAX_POINTS)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hee_update_unit #(
		.MAX_POINTS (MAX_POINTS)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.ratio     (ratio_q),
		.in_valid  (rv_q),
		.in_idx    (ridx_q),
		.in_value  (mem_rdata),
		.out_valid (upd_valid),
		.out_idx   (upd_idx),
		.out_value (upd_value),
		.busy      (upd_busy)
	);

`ifndef SYNTHESIS
	// Stencil results only land on interior points
	assert property (@(posedge clk) disable iff (!arst_n)
		upd_valid |-> (upd_idx != '0) && (upd_idx != last_q))
		else $error("stencil write to a boundary point");

	// New items are taken only with the stencil pipeline empty
	assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !rv_q && !upd_busy && !upd_valid)
		else $error("item accepted while the sweep is in flight");

	// A read with a free result register delivers on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) && !result_valid |=> result_valid)
		else $error("read result not delivered");

	// Boundary zeros follow a drained pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END_LO) |-> !upd_valid && !upd_busy)
		else $error("boundary write with stencil results pending");
`endif

endmodule

>>> hdl/hee_row_mem.sv
`timescale 1ns / 1ps

module hee_row_mem
	import hee_pkg::*;
#(
	parameter int DEPTH = MAX_POINTS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  temp_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output temp_t         rdata
);

	temp_t row_q [DEPTH];
	temp_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			row_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= row_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/hee_update_unit.sv
`timescale 1ns / 1ps

// Shared stencil unit: takes the old row one point per cycle, keeps a
// three-point window and produces the new value of the middle point.
module hee_update_unit
	import hee_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RATIO_W-1:0] ratio,
	input  logic               in_valid,
	input  logic [AW-1:0]      in_idx,
	input  temp_t              in_value,
	output logic               out_valid,
	output logic [AW-1:0]      out_idx,
	output temp_t              out_value,
	output logic               busy
);

	temp_t left_q, mid_q;

	logic                     v_s1, v_s2;
	logic [AW-1:0]            idx_s1, idx_s2;
	temp_t                    c_s1, c_s2;
	logic signed [DIFF_W-1:0] d_s1;
	logic signed [PROD_W-1:0] p_s2;

	logic                       window_full;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-FRAC_W-1:0] delta;
	logic signed [PROD_W-FRAC_W:0]   sum;

	// Window is complete once the right neighbor of an interior point arrives
	assign window_full = in_valid && (in_idx >= AW'(2));

	assign diff = DIFF_W'(left_q) + DIFF_W'(in_value) - (DIFF_W'(mid_q) <<< 1);

	// Sliding window over the old row
	always_ff @(posedge clk) begin
		if (in_valid) begin
			left_q <= mid_q;
			mid_q  <= in_value;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= window_full;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: second difference; stage 2: scale by the ratio
	always_ff @(posedge clk) begin
		d_s1   <= diff;
		c_s1   <= mid_q;
		idx_s1 <= in_idx - AW'(1);
		p_s2   <= $signed({1'b0, ratio}) * d_s1;
		c_s2   <= c_s1;
		idx_s2 <= idx_s1;
	end

	// Floor shift, add center, saturate
	assign delta = p_s2[PROD_W-1:FRAC_W];
	assign sum   = (PROD_W-FRAC_W+1)'(c_s2) + (PROD_W-FRAC_W+1)'(delta);

	always_comb begin
		priority if (sum > (PROD_W-FRAC_W+1)'(VAL_MAX)) begin
			out_value = VAL_MAX;
		end else if (sum < (PROD_W-FRAC_W+1)'(VAL_MIN)) begin
			out_value = VAL_MIN;
		end else begin
			out_value = sum[VAL_W-1:0];
		end
	end

	assign out_valid = v_s2;
	assign out_idx   = idx_s2;
	assign busy      = v_s1 || v_s2;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import hee_pkg::*;

	localparam int ITEMS_TARGET   = 900;
	localparam int PHASE_ITEMS    = 100;
	localparam int SETTLE_CYCLES  = 300;   // outlasts the longest advance
	localparam longint TIMEOUT_NS = 64'd50_000_000;

	// Codes the block must ignore
	localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	heat_equation_explicit_stencil DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Stimulus bookkeeping
	item_t   pending_items[$];
	result_t expected_reads[$];
	bit      point_loaded[MAX_POINTS_DEF];
	int      items_made = 0;
	bit      gaps_on = 1'b1;
	int      idle_left = 0;
	int      stall_left = 0;
	logic    item_sent = 1'b0;
	logic    cfg_sent = 1'b0;
	int      fail_count = 0;

	// Predicted rod state and registers
	temp_t              rod_temps[MAX_POINTS_DEF];
	logic [RATIO_W-1:0] diff_ratio = RATIO_RST;
	logic [NPTS_W-1:0]  grid_points = POINTS_RST;

	function automatic int clamp_points(logic [NPTS_W-1:0] p);
		if (p < 3)
			return 3;
		if (p > MAX_POINTS_DEF)
			return MAX_POINTS_DEF;
		return int'(p);
	endfunction

	// One FTCS time step over the rod, old row in, saturated new row out
	function automatic void advance_rod();
		temp_t  old_row[MAX_POINTS_DEF];
		int     n;
		longint lap, prod, sum;
		n = clamp_points(grid_points);
		old_row = rod_temps;
		for (int i = 1; i + 1 < n; i++) begin
			lap = longint'(old_row[i-1]) + longint'(old_row[i+1]) - 2 * longint'(old_row[i]);
			prod = lap * longint'(diff_ratio);
			sum = longint'(old_row[i]) + (prod >>> FRAC_W);
			if (sum > longint'(VAL_MAX))
				sum = longint'(VAL_MAX);
			if (sum < longint'(VAL_MIN))
				sum = longint'(VAL_MIN);
			rod_temps[i] = sum[VAL_W-1:0];
		end
		rod_temps[0] = '0;
		rod_temps[n-1] = '0;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	function automatic temp_t random_temp();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return temp_t'(int'($urandom_range(0, 2000)) - 1000);
			default: return temp_t'($urandom);
		endcase
	endfunction

	task automatic queue_item(input logic [OP_W-1:0] op, input int idx, input temp_t val);
		item_t it;
		it.opcode = op;
		it.point_index = idx[IDX_W-1:0];
		it.point_value = val;
		pending_items.push_back(it);
		if (op == OP_LOAD)
			point_loaded[idx] = 1'b1;
		if (op != OP_UNUSED)
			items_made++;
	endtask

	// Random traffic over the current grid: fill the rod first so every
	// advance and read only touches loaded points
	task automatic random_phase(input int count);
		int n, made, idx, pick;
		n = clamp_points(grid_points);
		for (int i = 0; i < n; i++)
			if (!point_loaded[i])
				queue_item(OP_LOAD, i, random_temp());
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, MAX_POINTS_DEF - 1);
			if (pick < 35) begin
				if ($urandom_range(0, 4) != 0)
					idx = $urandom_range(0, n - 1);
				queue_item(OP_LOAD, idx, random_temp());
				made++;
			end else if (pick < 60) begin
				queue_item(OP_ADVANCE, idx, temp_t'($urandom));
				made++;
			end else if (pick < 95) begin
				if (!point_loaded[idx])
					idx = $urandom_range(0, n - 1);
				queue_item(OP_READ, idx, temp_t'($urandom));
				made++;
			end else begin
				queue_item(OP_UNUSED, idx, temp_t'($urandom));
			end
		end
	endtask

	// Wait until all items are in and all reads are back, then let any advance finish
	task automatic drain_and_settle();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_reads.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk);
		while (!cfg_sent);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Item driver
	always @(negedge clk) begin
		if (item_valid && !item_sent) begin
			// hold until the transfer happens
		end else if (idle_left > 0) begin
			item_valid <= 1'b0;
			idle_left--;
		end else if (pending_items.size() != 0) begin
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				item_valid <= 1'b0;
				idle_left = $urandom_range(0, 9);
			end else begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
			end
		end else begin
			item_valid <= 1'b0;
		end
	end

	// Result receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			stall_left = $urandom_range(0, 9);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Monitor: predict on each accepted transfer, check each returned read
	always @(posedge clk) begin
		result_t want;
		item_sent <= item_valid && item_ready;
		cfg_sent <= cfg_valid && cfg_ready;

		if (item_valid && item_ready) begin
			case (item.opcode)
				OP_LOAD: rod_temps[item.point_index] = item.point_value;
				OP_ADVANCE: advance_rod();
				OP_READ: begin
					want.read_index = item.point_index;
					want.read_value = rod_temps[item.point_index];
					expected_reads.push_back(want);
				end
				default: ;
			endcase
		end

		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RATIO: diff_ratio = cfg_data[RATIO_W-1:0];
				CFG_POINTS: grid_points = cfg_data[NPTS_W-1:0];
				default: ;
			endcase
		end

		if (result_valid && result_ready) begin
			if (expected_reads.size() == 0) begin
				note_mismatch("unrequested read_index", -1, int'(result.read_index));
			end else begin
				want = expected_reads.pop_front();
				if (result.read_index !== want.read_index)
					note_mismatch("read_index", int'(want.read_index), int'(result.read_index));
				if (result.read_value !== want.read_value)
					note_mismatch("read_value", int'(want.read_value), int'(result.read_value));
			end
		end
	end

	// Sequence of phases
	initial begin
		logic [CFG_DATA_W-1:0] ratio_pick, points_pick;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: fill the whole rod, loaded ends and extremes next to each other
		for (int i = 0; i < MAX_POINTS_DEF; i++) begin
			case (i)
				0, 2: queue_item(OP_LOAD, i, VAL_MAX);
				1, MAX_POINTS_DEF - 1: queue_item(OP_LOAD, i, VAL_MIN);
				MAX_POINTS_DEF - 2: queue_item(OP_LOAD, i, -24'sd1);
				default: queue_item(OP_LOAD, i, random_temp());
			endcase
		end
		queue_item(OP_READ, 0, VAL_MIN);
		queue_item(OP_READ, MAX_POINTS_DEF - 1, VAL_MAX);
		queue_item(OP_UNUSED, 5, VAL_MAX);
		queue_item(OP_ADVANCE, 0, '0);
		queue_item(OP_READ, 0, '0);
		queue_item(OP_READ, 1, '0);
		queue_item(OP_READ, 2, '0);
		queue_item(OP_READ, MAX_POINTS_DEF - 1, '0);
		queue_item(OP_LOAD, 7, VAL_MAX);
		queue_item(OP_READ, 7, '0);
		queue_item(OP_ADVANCE, 0, '0);
		queue_item(OP_READ, 7, '0);
		queue_item(OP_READ, 128, '0);
		drain_and_settle();

		// Zero ratio on the shortest rod; points past the end keep their values
		write_reg(CFG_RATIO, 16'd0);
		write_reg(CFG_POINTS, 16'd3);
		queue_item(OP_LOAD, 0, VAL_MAX);
		queue_item(OP_LOAD, 1, -24'sd12345);
		queue_item(OP_LOAD, 2, VAL_MIN);
		queue_item(OP_ADVANCE, 0, '0);
		queue_item(OP_READ, 0, '0);
		queue_item(OP_READ, 1, '0);
		queue_item(OP_READ, 2, '0);
		queue_item(OP_READ, 200, '0);
		queue_item(OP_LOAD, 200, VAL_MAX);
		queue_item(OP_ADVANCE, 0, '0);
		queue_item(OP_READ, 200, '0);
		drain_and_settle();

		// Full ratio, a count that clamps up to three, writes to unused registers
		write_reg(CFG_RATIO, 16'hFFFF);
		write_reg(CFG_POINTS, 16'hFE00);
		write_reg(CFG_UNUSED_LO, 16'($urandom));
		write_reg(CFG_UNUSED_HI, 16'($urandom));
		random_phase(60);
		drain_and_settle();

		// Random settings; the final stretch runs without gaps
		while (items_made < ITEMS_TARGET) begin
			ratio_pick = 16'($urandom);
			case ($urandom_range(0, 5))
				0: ratio_pick = 16'd0;
				1: ratio_pick = 16'hFFFF;
				2: ratio_pick = 16'h8000;
				default: ;
			endcase
			points_pick = 16'($urandom);
			case ($urandom_range(0, 7))
				0: points_pick[NPTS_W-1:0] = 9'($urandom_range(0, 2));
				1: points_pick[NPTS_W-1:0] = 9'h1FF;
				2: points_pick[NPTS_W-1:0] = 9'(MAX_POINTS_DEF);
				3: points_pick[NPTS_W-1:0] = 9'($urandom_range(257, 511));
				default: points_pick[NPTS_W-1:0] = 9'($urandom_range(3, 40));
			endcase
			write_reg(CFG_RATIO, ratio_pick);
			write_reg(CFG_POINTS, points_pick);
			gaps_on = (items_made + PHASE_ITEMS < ITEMS_TARGET) && ($urandom_range(0, 3) != 0);
			random_phase(PHASE_ITEMS);
			drain_and_settle();
		end

		if (fail_count == 0 && expected_reads.size() == 0)
			$display("[heat_equation_explicit_stencil] OK");
		else
			$display("[heat_equation_explicit_stencil] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("[heat_equation_explicit_stencil] ERROR");
		$finish;
	end

endmodule
